/* rtl/euclidean_distance_accumulator_macros.svh */
// Assertion macros for the euclidean distance accumulator
`ifndef EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH
`define EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define EDA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/eda_pkg.sv */
// Shared types and constants for the euclidean distance accumulator
package eda_pkg;

	localparam int DIST_W = 44;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] ADDR_ROOT_MODE = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ADD,
		ST_RLOAD,
		ST_ROOT,
		ST_EMIT
	} eda_state_t;

	typedef struct packed {
		logic capture;
		logic square;
		logic accumulate;
		logic clear;
	} acc_ctl_t;

endpackage

/* rtl/eda_if.sv */
// Request and result channel interfaces
interface eda_in_if #(
	parameter int ELEM_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] x_elem;
	logic signed [ELEM_WIDTH-1:0] y_elem;
	logic                         last_elem;

	modport source (output valid, output x_elem, output y_elem, output last_elem,
		input ready);
	modport sink (input valid, input x_elem, input y_elem, input last_elem,
		output ready);
endinterface

interface eda_out_if;
	logic        valid;
	logic        ready;
	logic [43:0] distance;
	logic        saturated;

	modport source (output valid, output distance, output saturated, input ready);
	modport sink (input valid, input distance, input saturated, output ready);
endinterface

/* rtl/eda_accum.sv */
// Difference, square and saturating running sum
module eda_accum #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 44
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  eda_pkg::acc_ctl_t            ctl,
	input  logic signed [ELEM_WIDTH-1:0] x_elem,
	input  logic signed [ELEM_WIDTH-1:0] y_elem,
	output logic [ACC_WIDTH-1:0]         sum,
	output logic                         sat
);
	import eda_pkg::*;

	localparam int SQ_W = 2 * ELEM_WIDTH;
	localparam int SW   = (SQ_W > ACC_WIDTH) ? SQ_W : ACC_WIDTH;

	logic signed [ELEM_WIDTH:0] diff;
	logic [ELEM_WIDTH-1:0]      mag;
	logic [ELEM_WIDTH-1:0]      mag_q;
	logic [SQ_W-1:0]            sq_q;
	logic [ACC_WIDTH-1:0]       sum_q;
	logic                       sat_q;
	logic [SW:0]                sum_ext;
	logic [SW:0]                acc_max_ext;
	acc_ctl_t                   ctl_w;

	assign ctl_w = ctl;
	assign diff  = $signed({x_elem[ELEM_WIDTH-1], x_elem})
		- $signed({y_elem[ELEM_WIDTH-1], y_elem});
	assign mag   = diff[ELEM_WIDTH] ? ELEM_WIDTH'(-diff) : ELEM_WIDTH'(diff);

	assign sum_ext     = (SW+1)'(sum_q) + (SW+1)'(sq_q);
	assign acc_max_ext = (SW+1)'({ACC_WIDTH{1'b1}});

	always_ff @(posedge clk) begin
		if (ctl_w.capture) begin
			mag_q <= mag;
		end
		if (ctl_w.square) begin
			sq_q <= mag_q * mag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (ctl_w.clear) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (ctl_w.accumulate) begin
			if (sum_ext > acc_max_ext) begin
				sum_q <= {ACC_WIDTH{1'b1}};
				sat_q <= 1'b1;
			end else begin
				sum_q <= ACC_WIDTH'(sum_ext);
			end
		end
	end

	assign sum = sum_q;
	assign sat = sat_q;

endmodule

/* rtl/eda_root.sv */
// Bit-serial floor square root, one root bit per cycle
module eda_root #(
	parameter int ACC_WIDTH = 44
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ACC_WIDTH-1:0]           value,
	output logic                           busy,
	output logic [(ACC_WIDTH+1)/2-1:0]     root
);
	localparam int RW = (ACC_WIDTH + 1) / 2;
	localparam int NW = 2 * RW;
	localparam int CW = $clog2(RW + 1);

	logic [NW-1:0]   val_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic [RW+1:0]   rem_next;
	logic [RW+1:0]   trial;
	logic            fits;

	assign rem_next = {rem_q[RW-1:0], val_q[NW-1:NW-2]};
	assign trial    = {root_q, 2'b01};
	assign fits     = (rem_next >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(RW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= NW'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= {val_q[NW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule

/* rtl/euclidean_distance_accumulator.sv */
// Sequence: every element passes through the idle (capture), square and add states.
// A last element then goes to emit in squared mode, or through root load and the
// bit-serial root unit to emit in root mode; emit stalls while a held result is not taken.
// Elements are taken one at a time: in.ready is high only in the idle state.
// Reset (arst_n low, asynchronous) clears the sum, the clamp flag, root_mode and
// the sequencer; the block is ready for a request once reset is released.
module euclidean_distance_accumulator #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 44
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eda_pkg::APB_AW-1:0]   paddr,
	input  logic [eda_pkg::APB_DW-1:0]   pwdata,
	output logic [eda_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	eda_in_if.sink                       in,
	eda_out_if.source                    out
);
	import eda_pkg::*;

	localparam int RW = (ACC_WIDTH + 1) / 2;

	eda_state_t           state_q;
	eda_state_t           state_d;
	acc_ctl_t             acc_ctl;
	logic                 root_mode_q;
	logic                 last_q;
	logic                 root_start;
	logic                 root_busy;
	logic [RW-1:0]        root_val;
	logic [ACC_WIDTH-1:0] acc_sum;
	logic                 acc_sat;
	logic                 out_load;
	logic                 out_valid_q;
	logic [DIST_W-1:0]    dist_q;
	logic                 sat_out_q;
	logic [DIST_W-1:0]    dist_sq;
	logic [DIST_W-1:0]    dist_rt;
	logic                 cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_ROOT_MODE) ? {(APB_DW-1)'(0), root_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_mode_q <= 1'b0;
		end else if (cfg_wr && (paddr == ADDR_ROOT_MODE)) begin
			root_mode_q <= pwdata[0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in.valid) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (!last_q) state_d = ST_IDLE;
				else if (root_mode_q) state_d = ST_RLOAD;
				else state_d = ST_EMIT;
			end
			ST_RLOAD: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (!root_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in.ready           = (state_q == ST_IDLE);
		out_load           = (state_q == ST_EMIT) && (!out_valid_q || out.ready);
		root_start         = (state_q == ST_RLOAD);
		acc_ctl.capture    = in.valid && (state_q == ST_IDLE);
		acc_ctl.square     = (state_q == ST_SQUARE);
		acc_ctl.accumulate = (state_q == ST_ADD);
		acc_ctl.clear      = out_load;
	end

	always_ff @(posedge clk) begin
		if (acc_ctl.capture) begin
			last_q <= in.last_elem;
		end
	end

	eda_accum #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.x_elem (in.x_elem),
		.y_elem (in.y_elem),
		.sum    (acc_sum),
		.sat    (acc_sat)
	);

	eda_root #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (acc_sum),
		.busy   (root_busy),
		.root   (root_val)
	);

	// result register
	assign dist_sq = DIST_W'(acc_sum);
	assign dist_rt = DIST_W'(root_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dist_q    <= root_mode_q ? dist_rt : dist_sq;
			sat_out_q <= acc_sat;
		end
	end

	assign out.valid     = out_valid_q;
	assign out.distance  = dist_q;
	assign out.saturated = sat_out_q;

	`include "euclidean_distance_accumulator_macros.svh"

	`EDA_ASSERT_SAME(a_sat_at_max, acc_sat, acc_sum == {ACC_WIDTH{1'b1}}, "clamp flag set below max")
	`EDA_ASSERT_NEXT(a_sum_hold, (state_q != ST_ADD) && (state_q != ST_EMIT), $stable(acc_sum), "sum moved outside add or emit")
	`EDA_ASSERT_NEXT(a_emit_clears, out_load, out.valid && (acc_sum == '0) && !acc_sat, "emit did not post result and clear")

endmodule

/* bench/euclidean_distance_accumulator_tb.sv */
// Self-checking testbench for the euclidean distance accumulator: element streams, APB mode register
`timescale 1ns / 1ps

module euclidean_distance_accumulator_tb;
	import eda_pkg::*;

	localparam int ELEM_W = 16;
	localparam int ACC_W = 44;
	localparam logic [ACC_W-1:0] ACC_FULL = '1;
	localparam int ITEMS_PER_SETTING = 180;
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int CLAMP_RUN = 4096;

	typedef struct packed {
		logic signed [ELEM_W-1:0] x_elem;
		logic signed [ELEM_W-1:0] y_elem;
		logic                     last_elem;
	} elem_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              saturated;
	} dist_res_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	eda_in_if #(.ELEM_WIDTH(ELEM_W)) in_if ();
	eda_out_if out_if ();

	euclidean_distance_accumulator #(
		.ELEM_WIDTH(ELEM_W),
		.ACC_WIDTH (ACC_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in     (in_if),
		.out    (out_if)
	);

	elem_req_t        pending_reqs[$];
	dist_res_t        dist_expect_q[$];
	logic [ACC_W-1:0] sum_model = '0;
	logic             sat_model = 1'b0;
	logic             root_model = 1'b0;
	logic             req_taken = 1'b0;
	int               src_idle_pct = 0;
	int               sink_idle_pct = 0;
	int               n_errors = 0;
	int               n_elems = 0;
	int               n_results = 0;
	int               n_sat_results = 0;
	int               n_root_results = 0;
	int               stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DIST_W-1:0] floor_sqrt(input logic [ACC_W-1:0] v);
		logic [ACC_W/2-1:0] r;
		logic [ACC_W/2-1:0] t;
		logic [ACC_W-1:0]   tt;
		r = '0;
		for (int b = ACC_W/2 - 1; b >= 0; b--) begin
			t = r | (1 << b);
			tt = t;
			if (tt * tt <= v)
				r = t;
		end
		return DIST_W'(r);
	endfunction

	function automatic logic accumulate_elem(input elem_req_t r, output dist_res_t res);
		logic [ELEM_W-1:0] xb;
		logic [ELEM_W-1:0] yb;
		logic [ELEM_W-1:0] mag;
		logic [ACC_W-1:0]  sq;
		xb = r.x_elem ^ {1'b1, {(ELEM_W-1){1'b0}}};
		yb = r.y_elem ^ {1'b1, {(ELEM_W-1){1'b0}}};
		mag = (xb >= yb) ? xb - yb : yb - xb;
		sq = ACC_W'(mag) * ACC_W'(mag);
		if (sq > ACC_FULL - sum_model) begin
			sum_model = ACC_FULL;
			sat_model = 1'b1;
		end else begin
			sum_model = sum_model + sq;
		end
		res = '0;
		if (!r.last_elem)
			return 1'b0;
		res.distance = root_model ? floor_sqrt(sum_model) : DIST_W'(sum_model);
		res.saturated = sat_model;
		sum_model = '0;
		sat_model = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_elem();
		case ($urandom_range(7))
			0: return {1'b1, {(ELEM_W-1){1'b0}}};
			1: return {1'b0, {(ELEM_W-1){1'b1}}};
			2: return '0;
			3: return ELEM_W'($signed($urandom_range(511)) - 256);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic void push_req(input logic signed [ELEM_W-1:0] x,
		input logic signed [ELEM_W-1:0] y, input logic last);
		pending_reqs.push_back(elem_req_t'{x, y, last});
	endfunction

	function automatic void push_vector(input int len);
		for (int i = 0; i < len; i++)
			push_req(pick_elem(), pick_elem(), i == len - 1);
	endfunction

	// drive the sum to just below its maximum, then add the tail pair and any extra elements
	function automatic void push_clamp_vector(input logic signed [ELEM_W-1:0] tail_x,
		input logic signed [ELEM_W-1:0] tail_y, input int extra);
		for (int i = 0; i < CLAMP_RUN; i++) begin
			if (i[0])
				push_req(16'sh7FFF, 16'sh8000, 1'b0);
			else
				push_req(16'sh8000, 16'sh7FFF, 1'b0);
		end
		push_req(16'sd11585, -16'sd11585, 1'b0);
		push_req(tail_x, tail_y, extra == 0);
		if (extra > 0)
			push_vector(extra);
	endfunction

	task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_ROOT_MODE)
			root_model = data[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_root_mode();
		logic [APB_DW-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_ROOT_MODE;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[0] !== root_model) begin
			$error("root_mode readback mismatch: expected %0d, actual %0d", root_model, rd[0]);
			n_errors++;
		end
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || in_if.valid || dist_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		elem_req_t nxt;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_reqs.pop_front();
				in_if.valid <= 1'b1;
				in_if.x_elem <= nxt.x_elem;
				in_if.y_elem <= nxt.y_elem;
				in_if.last_elem <= nxt.last_elem;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		out_if.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		elem_req_t req;
		dist_res_t res;
		req_taken <= in_if.valid && in_if.ready;
		if (arst_n && in_if.valid && in_if.ready) begin
			req.x_elem = in_if.x_elem;
			req.y_elem = in_if.y_elem;
			req.last_elem = in_if.last_elem;
			n_elems++;
			if (accumulate_elem(req, res))
				dist_expect_q.push_back(res);
		end
	end

	always @(posedge clk) begin
		dist_res_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (dist_expect_q.size() == 0) begin
				$error("unexpected result: distance %0d, saturated %0d",
					out_if.distance, out_if.saturated);
				n_errors++;
			end else begin
				want = dist_expect_q.pop_front();
				if (out_if.distance !== want.distance) begin
					$error("distance mismatch: expected %0d, actual %0d",
						want.distance, out_if.distance);
					n_errors++;
				end
				if (out_if.saturated !== want.saturated) begin
					$error("saturated mismatch: expected %0d, actual %0d",
						want.saturated, out_if.saturated);
					n_errors++;
				end
				n_results++;
				if (want.saturated)
					n_sat_results++;
				if (root_model)
					n_root_results++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				stall_cycles, dist_expect_q.size());
			$display("[euclidean_distance_accumulator] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [APB_DW-1:0] wdata;
		int                pushed;
		int                len;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 1'b0;
		in_if.x_elem = '0;
		in_if.y_elem = '0;
		in_if.last_elem = 1'b0;
		out_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 7;
		sink_idle_pct = 64;
		check_root_mode();

		push_req(16'sh7FFF, 16'sh8000, 1'b1);
		push_req(16'sh8000, 16'sh7FFF, 1'b1);
		push_req(16'sh0000, 16'sh0000, 1'b1);
		push_req(16'sh8000, 16'sh8000, 1'b0);
		push_req(16'sh7FFF, 16'sh7FFF, 1'b1);
		push_req(16'sh0001, 16'sh0000, 1'b1);
		push_req(16'sh0000, 16'sh0001, 1'b1);
		push_req(16'shFFFF, 16'sh0001, 1'b0);
		push_req(16'sh0100, 16'shFF00, 1'b0);
		push_req(16'sh1234, 16'sh4321, 1'b1);
		push_req(16'shAAAA, 16'sh5555, 1'b1);
		push_req(16'sh5555, 16'shAAAA, 1'b1);
		push_vector(6);
		settle();

		for (int p = 0; p < 3; p++) begin
			src_idle_pct = (p == 0) ? 7 : (p == 1) ? 64 : 0;
			sink_idle_pct = (p == 0) ? 64 : (p == 1) ? 7 : 0;
			for (int m = 0; m < 2; m++) begin
				wdata = $urandom;
				wdata[0] = m[0];
				cfg_write(ADDR_ROOT_MODE, wdata);
				check_root_mode();
				pushed = 0;
				while (pushed < ITEMS_PER_SETTING) begin
					len = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
					push_vector(len);
					pushed += len;
				end
				// stop one step short of the clamp, then step past it
				if (p == 2 && m == 1)
					push_clamp_vector(16'sd67, -16'sd67, 3);
				settle();
			end
		end

		$display("checked %0d element pairs in %0d vectors, %0d of them in root mode",
			n_elems, n_results, n_root_results);
		$display("%0d vectors hit the clamp, %0d mismatches", n_sat_results, n_errors);
		if (n_errors == 0)
			$display("[euclidean_distance_accumulator] OK");
		else
			$display("[euclidean_distance_accumulator] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/eda_pkg.sv
rtl/eda_if.sv
rtl/eda_accum.sv
rtl/eda_root.sv
rtl/euclidean_distance_accumulator.sv
bench/euclidean_distance_accumulator_tb.sv
